FILE: hdl/pdsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdsu_pkg
// Shared constants, register map, micro-op codes and the control store of the
// PID differential steering unit.
// ----------------------------------------------------------------------------
package pdsu_pkg;

  // default fraction bits of error, gains and pid
  localparam int unsigned FRAC_BITS_DEF = 16;

  // register map
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned TMO_W  = 16;
  localparam logic [1:0] REG_KP  = 2'd0;
  localparam logic [1:0] REG_KI  = 2'd1;
  localparam logic [1:0] REG_KD  = 2'd2;
  localparam logic [1:0] REG_TMO = 2'd3;
  localparam logic [GAIN_W-1:0] KP_RESET  = 24'd9830;
  localparam logic [GAIN_W-1:0] KI_RESET  = 24'd0;
  localparam logic [GAIN_W-1:0] KD_RESET  = 24'd0;
  localparam logic [TMO_W-1:0]  TMO_RESET = 16'd500;

  // datapath widths
  localparam int unsigned TERM_W   = 48;
  localparam logic [63:0] TERM_CAP = 64'h0000_8000_0000_0000;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned DIV_BITS = 57;
  localparam int unsigned CNT_W    = $clog2(DIV_BITS + 1);

  // micro-ops
  localparam logic [3:0] U_WAIT     = 4'd0;
  localparam logic [3:0] U_MUL_ED   = 4'd1;
  localparam logic [3:0] U_INTEG    = 4'd2;
  localparam logic [3:0] U_MUL_P    = 4'd3;
  localparam logic [3:0] U_CAP_P    = 4'd4;
  localparam logic [3:0] U_ADD_T    = 4'd5;
  localparam logic [3:0] U_MUL_IL   = 4'd6;
  localparam logic [3:0] U_MUL_IH   = 4'd7;
  localparam logic [3:0] U_CAP_I    = 4'd8;
  localparam logic [3:0] U_MUL_D    = 4'd9;
  localparam logic [3:0] U_DIV_INIT = 4'd10;
  localparam logic [3:0] U_DIV_STEP = 4'd11;
  localparam logic [3:0] U_CAP_D    = 4'd12;
  localparam logic [3:0] U_CLAMP    = 4'd13;
  localparam logic [3:0] U_OUT_S    = 4'd14;
  localparam logic [3:0] U_OUT_P    = 4'd15;

  // jump conditions
  localparam logic [2:0] C_NONE    = 3'd0;
  localparam logic [2:0] C_ALWAYS  = 3'd1;
  localparam logic [2:0] C_POLL    = 3'd2;
  localparam logic [2:0] C_DTZERO  = 3'd3;
  localparam logic [2:0] C_DIVBUSY = 3'd4;

  // program addresses
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
  localparam logic [PC_W-1:0] PC_FIRST = 5'd1;
  localparam logic [PC_W-1:0] PC_DIV   = 5'd12;
  localparam logic [PC_W-1:0] PC_CLAMP = 5'd15;
  localparam logic [PC_W-1:0] PC_OUT_S = 5'd16;
  localparam logic [PC_W-1:0] PC_OUT_P = 5'd17;

  typedef struct packed {
    logic [3:0]      uop;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{uop: U_WAIT, cond: C_NONE, target: PC_WAIT};
    case (addr)
      5'd0:  w = '{uop: U_WAIT,     cond: C_POLL,    target: PC_OUT_P};
      5'd1:  w = '{uop: U_MUL_ED,   cond: C_NONE,    target: PC_WAIT};
      5'd2:  w = '{uop: U_INTEG,    cond: C_NONE,    target: PC_WAIT};
      5'd3:  w = '{uop: U_MUL_P,    cond: C_NONE,    target: PC_WAIT};
      5'd4:  w = '{uop: U_CAP_P,    cond: C_NONE,    target: PC_WAIT};
      5'd5:  w = '{uop: U_ADD_T,    cond: C_NONE,    target: PC_WAIT};
      5'd6:  w = '{uop: U_MUL_IL,   cond: C_NONE,    target: PC_WAIT};
      5'd7:  w = '{uop: U_MUL_IH,   cond: C_NONE,    target: PC_WAIT};
      5'd8:  w = '{uop: U_CAP_I,    cond: C_NONE,    target: PC_WAIT};
      5'd9:  w = '{uop: U_ADD_T,    cond: C_NONE,    target: PC_WAIT};
      5'd10: w = '{uop: U_MUL_D,    cond: C_DTZERO,  target: PC_CLAMP};
      5'd11: w = '{uop: U_DIV_INIT, cond: C_NONE,    target: PC_WAIT};
      5'd12: w = '{uop: U_DIV_STEP, cond: C_DIVBUSY, target: PC_DIV};
      5'd13: w = '{uop: U_CAP_D,    cond: C_NONE,    target: PC_WAIT};
      5'd14: w = '{uop: U_ADD_T,    cond: C_NONE,    target: PC_WAIT};
      5'd15: w = '{uop: U_CLAMP,    cond: C_NONE,    target: PC_WAIT};
      5'd16: w = '{uop: U_OUT_S,    cond: C_ALWAYS,  target: PC_WAIT};
      5'd17: w = '{uop: U_OUT_P,    cond: C_ALWAYS,  target: PC_WAIT};
      default: w = '{uop: U_WAIT,   cond: C_ALWAYS,  target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pid_differential_steering_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_differential_steering_unit
// Microcoded PID steering: a control store drives one shared 33x32 multiplier,
// a saturating accumulator and a one-bit-per-cycle restoring divider.
// A sample runs the whole program from input transfer to result valid; when elapsed
// time is zero the derivative term and its divider steps are skipped.
// A poll goes straight to its output step; the input stalls outside the wait step.
// A result waiting on a stalled output holds the sequencer at its output step.
// Reset clears controller state and restores the register reset values.
// ----------------------------------------------------------------------------
module pid_differential_steering_unit #(
  parameter int unsigned FRAC_BITS = pdsu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdsu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [31:0]                  now_ms_i,
  input  logic signed [31:0]           error_value_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [16:0]                  speed_left_o,
  output logic [16:0]                  speed_right_o,
  output logic                         stopped_o,
  output logic                         updated_o
);

  localparam int unsigned AW = pdsu_pkg::ACC_W;
  localparam int unsigned TW = pdsu_pkg::TERM_W;
  localparam int unsigned CW = pdsu_pkg::CNT_W;
  localparam int unsigned DB = pdsu_pkg::DIV_BITS;
  localparam logic signed [AW-1:0] ONE_ACC = AW'(64'd1 << FRAC_BITS);
  localparam logic [FRAC_BITS:0]   ONE_P   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [63:0]          PHI_LIM = 64'd1 << (15 + FRAC_BITS);

  // configuration registers
  logic [pdsu_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [pdsu_pkg::TMO_W-1:0]  tmo_q;
  logic                        cfg_wr;

  // sequencer
  logic [pdsu_pkg::PC_W-1:0] pc_q, pc_d;
  pdsu_pkg::ucode_t          cur;
  logic                      in_xfer, step_hold, jump, out_load;

  // controller state
  logic signed [63:0] integ_q;
  logic [31:0]        prev_q, last_q;
  logic               seen_q;

  // datapath registers
  logic [31:0]          now_q, err_q, err_mag_q, dt_q;
  logic                 err_neg_q;
  logic signed [32:0]   diff_q;
  logic [32:0]          dif_mag_q;
  logic                 dif_neg_q;
  logic [64:0]          prod_q;
  logic [55:0]          plo_q;
  logic [63:0]          imag_q;
  logic [TW-1:0]        tmag_q;
  logic                 tneg_q;
  logic signed [AW-1:0] acc_q;
  logic [DB-1:0]        div_quo_q;
  logic [31:0]          div_rem_q;
  logic [CW-1:0]        div_cnt_q;
  logic [FRAC_BITS:0]   pmag_q;
  logic                 pneg_q;

  // output register
  logic        out_valid_q;
  logic [16:0] speed_left_q, speed_right_q;
  logic        stopped_q, updated_q;

  // combinational datapath
  logic [32:0]           mul_a;
  logic [31:0]           mul_b;
  logic [64:0]           mul_res;
  logic signed [64:0]    isum;
  logic signed [63:0]    integ_sat;
  logic [63:0]           term_r, term_cap;
  logic [32:0]           div_shift;
  logic                  div_ge;
  logic [FRAC_BITS:0]    inner;
  logic [FRAC_BITS+16:0] inner_ext;
  logic [31:0]           poll_elapsed;
  logic                  poll_stop;

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= pdsu_pkg::KP_RESET;
      ki_q  <= pdsu_pkg::KI_RESET;
      kd_q  <= pdsu_pkg::KD_RESET;
      tmo_q <= pdsu_pkg::TMO_RESET;
    end else if (cfg_wr) begin
      case (paddr[pdsu_pkg::ADDR_W-1:2])
        pdsu_pkg::REG_KP:  kp_q  <= pwdata[pdsu_pkg::GAIN_W-1:0];
        pdsu_pkg::REG_KI:  ki_q  <= pwdata[pdsu_pkg::GAIN_W-1:0];
        pdsu_pkg::REG_KD:  kd_q  <= pwdata[pdsu_pkg::GAIN_W-1:0];
        pdsu_pkg::REG_TMO: tmo_q <= pwdata[pdsu_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[pdsu_pkg::ADDR_W-1:2])
      pdsu_pkg::REG_KP:  prdata = {8'd0, kp_q};
      pdsu_pkg::REG_KI:  prdata = {8'd0, ki_q};
      pdsu_pkg::REG_KD:  prdata = {8'd0, kd_q};
      pdsu_pkg::REG_TMO: prdata = {16'd0, tmo_q};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: fetch, hold and branch
  assign cur        = pdsu_pkg::ucode_rom(pc_q);
  assign in_stall_o = (cur.uop != pdsu_pkg::U_WAIT);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    step_hold = 1'b0;
    if (cur.uop == pdsu_pkg::U_WAIT) begin
      step_hold = !in_valid_i;
    end else if (cur.uop == pdsu_pkg::U_OUT_S || cur.uop == pdsu_pkg::U_OUT_P) begin
      step_hold = out_valid_q && out_stall_i;
    end
    case (cur.cond)
      pdsu_pkg::C_NONE:    jump = 1'b0;
      pdsu_pkg::C_ALWAYS:  jump = 1'b1;
      pdsu_pkg::C_POLL:    jump = op_i;
      pdsu_pkg::C_DTZERO:  jump = (dt_q == 32'd0);
      pdsu_pkg::C_DIVBUSY: jump = (div_cnt_q != CW'(1));
      default:             jump = 1'b0;
    endcase
    if (step_hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = cur.target;
    end else begin
      pc_d = pc_q + pdsu_pkg::PC_W'(1);
    end
  end

  assign out_load = !step_hold &&
                    (cur.uop == pdsu_pkg::U_OUT_S || cur.uop == pdsu_pkg::U_OUT_P);

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  always_comb begin
    mul_a = 33'd0;
    mul_b = 32'd0;
    case (cur.uop)
      pdsu_pkg::U_MUL_ED: begin
        mul_a = {1'b0, err_mag_q};
        mul_b = dt_q;
      end
      pdsu_pkg::U_MUL_P: begin
        mul_a = {1'b0, err_mag_q};
        mul_b = {8'd0, kp_q};
      end
      pdsu_pkg::U_MUL_IL: begin
        mul_a = {1'b0, imag_q[31:0]};
        mul_b = {8'd0, ki_q};
      end
      pdsu_pkg::U_MUL_IH: begin
        mul_a = {1'b0, imag_q[63:32]};
        mul_b = {8'd0, ki_q};
      end
      pdsu_pkg::U_MUL_D: begin
        mul_a = dif_mag_q;
        mul_b = {8'd0, kd_q};
      end
      default: ;
    endcase
  end

  assign mul_res = 65'(mul_a) * 65'(mul_b);

  // saturating integral update
  always_comb begin
    if (err_neg_q) begin
      isum = {integ_q[63], integ_q} - {1'b0, prod_q[63:0]};
    end else begin
      isum = {integ_q[63], integ_q} + {1'b0, prod_q[63:0]};
    end
    if (isum[64] != isum[63]) begin
      integ_sat = isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      integ_sat = isum[63:0];
    end
  end

  // term scaling and saturation
  always_comb begin
    case (cur.uop)
      pdsu_pkg::U_CAP_I: begin
        if (prod_q[63:0] >= PHI_LIM) begin
          term_r = pdsu_pkg::TERM_CAP;
        end else begin
          term_r = (prod_q[63:0] << (32 - FRAC_BITS)) + ({8'd0, plo_q} >> FRAC_BITS);
        end
      end
      pdsu_pkg::U_CAP_D: term_r = 64'(div_quo_q) >> FRAC_BITS;
      default:           term_r = prod_q[63:0] >> FRAC_BITS;
    endcase
    term_cap = (term_r >= pdsu_pkg::TERM_CAP) ? pdsu_pkg::TERM_CAP : term_r;
  end

  // restoring divider step
  assign div_shift = {div_rem_q, div_quo_q[DB-1]};
  assign div_ge    = (div_shift >= {1'b0, dt_q});

  // wheel speed and poll timeout
  assign inner        = ONE_P - {1'b0, pmag_q[FRAC_BITS:1]};
  assign inner_ext    = {inner, 16'd0} >> FRAC_BITS;
  assign poll_elapsed = now_q - last_q;
  assign poll_stop    = !seen_q || (poll_elapsed >= {16'd0, tmo_q});

  // ---------------------------------------------------------------------------
  // control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pdsu_pkg::PC_WAIT;
      integ_q     <= 64'sd0;
      prev_q      <= 32'd0;
      last_q      <= 32'd0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cur.uop == pdsu_pkg::U_INTEG) begin
        integ_q <= integ_sat;
      end
      if (cur.uop == pdsu_pkg::U_CLAMP) begin
        prev_q <= err_q;
        last_q <= now_q;
        seen_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cur.uop)
      pdsu_pkg::U_WAIT: begin
        if (in_xfer) begin
          now_q     <= now_ms_i;
          err_q     <= error_value_i;
          err_neg_q <= error_value_i[31];
          err_mag_q <= error_value_i[31] ? (32'd0 - error_value_i) : error_value_i;
          dt_q      <= seen_q ? (now_ms_i - last_q) : 32'd0;
          acc_q     <= '0;
        end
      end
      pdsu_pkg::U_MUL_ED: begin
        prod_q <= mul_res;
        diff_q <= {err_q[31], err_q} - {prev_q[31], prev_q};
      end
      pdsu_pkg::U_INTEG: begin
        dif_neg_q <= diff_q[32];
        dif_mag_q <= diff_q[32] ? (33'd0 - diff_q) : diff_q;
      end
      pdsu_pkg::U_MUL_P: begin
        prod_q <= mul_res;
        imag_q <= integ_q[63] ? (64'd0 - integ_q) : integ_q;
      end
      pdsu_pkg::U_CAP_P: begin
        tmag_q <= term_cap[TW-1:0];
        tneg_q <= err_neg_q;
      end
      pdsu_pkg::U_ADD_T: begin
        if (tneg_q) begin
          acc_q <= acc_q - $signed(AW'(tmag_q));
        end else begin
          acc_q <= acc_q + $signed(AW'(tmag_q));
        end
      end
      pdsu_pkg::U_MUL_IL: prod_q <= mul_res;
      pdsu_pkg::U_MUL_IH: begin
        plo_q  <= prod_q[55:0];
        prod_q <= mul_res;
      end
      pdsu_pkg::U_CAP_I: begin
        tmag_q <= term_cap[TW-1:0];
        tneg_q <= integ_q[63];
      end
      pdsu_pkg::U_MUL_D: prod_q <= mul_res;
      pdsu_pkg::U_DIV_INIT: begin
        div_quo_q <= prod_q[DB-1:0];
        div_rem_q <= 32'd0;
        div_cnt_q <= CW'(DB);
      end
      pdsu_pkg::U_DIV_STEP: begin
        div_rem_q <= div_ge ? 32'(div_shift - {1'b0, dt_q}) : div_shift[31:0];
        div_quo_q <= {div_quo_q[DB-2:0], div_ge};
        div_cnt_q <= div_cnt_q - CW'(1);
      end
      pdsu_pkg::U_CAP_D: begin
        tmag_q <= term_cap[TW-1:0];
        tneg_q <= dif_neg_q;
      end
      pdsu_pkg::U_CLAMP: begin
        if (acc_q > ONE_ACC) begin
          pmag_q <= ONE_P;
          pneg_q <= 1'b0;
        end else if (acc_q < -ONE_ACC) begin
          pmag_q <= ONE_P;
          pneg_q <= 1'b1;
        end else begin
          pneg_q <= acc_q[AW-1];
          pmag_q <= acc_q[AW-1] ? (ONE_P - ONE_P - acc_q[FRAC_BITS:0]) : acc_q[FRAC_BITS:0];
        end
      end
      pdsu_pkg::U_OUT_S: begin
        if (out_load) begin
          speed_left_q  <= pneg_q ? 17'h10000 : inner_ext[16:0];
          speed_right_q <= pneg_q ? inner_ext[16:0] : 17'h10000;
          stopped_q     <= 1'b0;
          updated_q     <= 1'b1;
        end
      end
      pdsu_pkg::U_OUT_P: begin
        if (out_load) begin
          speed_left_q  <= 17'd0;
          speed_right_q <= 17'd0;
          stopped_q     <= poll_stop;
          updated_q     <= poll_stop;
        end
      end
      default: ;
    endcase
  end

  // output port
  assign out_valid_o   = out_valid_q;
  assign speed_left_o  = speed_left_q;
  assign speed_right_o = speed_right_q;
  assign stopped_o     = stopped_q;
  assign updated_o     = updated_q;

`ifndef SYNTH
  // an accepted item starts either the sample program or the poll step
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (pc_q == pdsu_pkg::PC_FIRST || pc_q == pdsu_pkg::PC_OUT_P))
    else $error("bad dispatch after input transfer");

  // a waiting result is never dropped by the sequencer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("pending result lost");

  // clamped pid magnitude never exceeds one
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == pdsu_pkg::PC_OUT_S) |-> (pmag_q <= ONE_P))
    else $error("pid magnitude out of range");

  // divider never runs past its last step
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur.uop == pdsu_pkg::U_DIV_STEP) |-> (div_cnt_q != CW'(0)))
    else $error("divider step count underflow");
`endif

endmodule
`default_nettype wire
